// ===== rtl/pdif_pkg.sv =====
// Shared types and constants for the decimal integer field formatter.
// Used by pdif_front, pdif_queue, pdif_back and the top level; no dependencies.
`default_nettype none

package pdif_pkg;

    // Field geometry
    localparam int MAX_FIELD   = 64;
    localparam int FIELD_W     = 7;
    localparam int PREC_W      = 6;
    localparam int VALUE_W     = 64;
    localparam int NUM_DIGITS  = 20;
    localparam int DIGIT_IDX_W = 5;
    localparam int ND_W        = 5;
    localparam int ITER_W      = 7;
    localparam int QUEUE_DEPTH = 2;

    // Conversion kinds
    localparam logic FUNC_SIGNED   = 1'b0;
    localparam logic FUNC_UNSIGNED = 1'b1;

    // Size modes
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_SHORT = 2'd1;
    localparam logic [1:0] SIZE_LONG  = 2'd2;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [3:0] DIGIT_HIGH_NIBBLE = 4'h3;

    // One formatted field: BCD digits plus the end position of each segment
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] bcd;
        logic [7:0]                 sign_char;
        logic [FIELD_W-1:0]         lead_end;
        logic [FIELD_W-1:0]         sign_end;
        logic [FIELD_W-1:0]         zero_end;
        logic [FIELD_W-1:0]         digit_end;
        logic [FIELD_W-1:0]         total;
    } t_desc;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_COUNT,
        FS_PUSH
    } t_front_state;

endpackage

`default_nettype wire

// ===== rtl/pdif_front.sv =====
// Front end: accepts a request, decodes sign and size, converts the magnitude to BCD
// by shift-and-add-3 and lays out the field segments. Depends on pdif_pkg.
`default_nettype none

module pdif_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic                                   i_func,
    input  wire logic signed [pdif_pkg::VALUE_W-1:0]    i_value,
    input  wire logic [1:0]                             i_size_mode,
    input  wire logic                                   i_left_align,
    input  wire logic                                   i_force_plus,
    input  wire logic                                   i_space_sign,
    input  wire logic                                   i_zero_pad,
    input  wire logic [pdif_pkg::FIELD_W-1:0]           i_field_width,
    input  wire logic                                   i_precision_given,
    input  wire logic [pdif_pkg::PREC_W-1:0]            i_digit_precision,
    input  wire pdif_pkg::t_q_status                    i_q_status,
    output logic                                        o_push,
    output pdif_pkg::t_desc                             o_desc
);

    pdif_pkg::t_front_state r_state, n_state;

    logic [pdif_pkg::VALUE_W-1:0]                 r_bin;
    logic [pdif_pkg::NUM_DIGITS-1:0][3:0]         r_bcd;
    logic [pdif_pkg::ITER_W-1:0]                  r_iter;
    logic [7:0]                                   r_sign_char;
    logic                                         r_has_sign;
    logic                                         r_left;
    logic                                         r_zp;
    logic                                         r_prec_given;
    logic [pdif_pkg::PREC_W-1:0]                  r_prec;
    logic [pdif_pkg::FIELD_W-1:0]                 r_width;
    logic [pdif_pkg::ND_W-1:0]                    r_nd;
    logic [pdif_pkg::FIELD_W-1:0]                 r_body;
    logic [pdif_pkg::FIELD_W-1:0]                 r_pad;

    logic                                         accept;
    logic                                         neg;
    logic [pdif_pkg::VALUE_W-1:0]                 load_bin;
    logic [pdif_pkg::ITER_W-1:0]                  load_iter;
    logic [31:0]                                  mag32;
    logic [15:0]                                  mag16;
    logic [pdif_pkg::VALUE_W-1:0]                 mag64;
    logic [7:0]                                   sign_char;
    logic                                         has_sign;
    logic [pdif_pkg::FIELD_W-1:0]                 width_sat;

    logic [pdif_pkg::NUM_DIGITS-1:0][3:0]         adj;
    logic [pdif_pkg::NUM_DIGITS*4-1:0]            adj_flat;
    logic [pdif_pkg::NUM_DIGITS*4-1:0]            n_bcd_flat;

    logic [pdif_pkg::NUM_DIGITS-1:0]              nz;
    logic [pdif_pkg::ND_W-1:0]                    nd_raw;
    logic [pdif_pkg::ND_W-1:0]                    nd;
    logic [pdif_pkg::FIELD_W-1:0]                 body;
    logic [pdif_pkg::FIELD_W-1:0]                 total;
    logic [pdif_pkg::FIELD_W-1:0]                 pad;

    logic [pdif_pkg::FIELD_W-1:0]                 lead;
    logic [pdif_pkg::FIELD_W-1:0]                 zeros;
    logic [pdif_pkg::FIELD_W-1:0]                 trail;
    logic                                         field_empty;

    assign accept = i_valid && o_ready;

    // Decode size, sign and magnitude of the incoming request
    always_comb begin
        mag32 = i_value[31:0];
        mag16 = i_value[15:0];
        mag64 = i_value;
        unique case (i_size_mode)
            pdif_pkg::SIZE_INT: begin
                neg       = (i_func == pdif_pkg::FUNC_SIGNED) && i_value[31];
                mag32     = neg ? (~i_value[31:0] + 32'd1) : i_value[31:0];
                load_bin  = {mag32, 32'd0};
                load_iter = 7'd32;
            end
            pdif_pkg::SIZE_SHORT: begin
                neg       = (i_func == pdif_pkg::FUNC_SIGNED) && i_value[15];
                mag16     = neg ? (~i_value[15:0] + 16'd1) : i_value[15:0];
                load_bin  = {mag16, 48'd0};
                load_iter = 7'd16;
            end
            default: begin
                neg       = (i_func == pdif_pkg::FUNC_SIGNED) && i_value[63];
                mag64     = neg ? (~i_value + 64'd1) : i_value;
                load_bin  = mag64;
                load_iter = 7'd64;
            end
        endcase

        has_sign  = 1'b1;
        sign_char = pdif_pkg::CHAR_SPACE;
        priority if (i_func != pdif_pkg::FUNC_SIGNED) begin
            has_sign = 1'b0;
        end else if (neg) begin
            sign_char = pdif_pkg::CHAR_MINUS;
        end else if (i_force_plus) begin
            sign_char = pdif_pkg::CHAR_PLUS;
        end else if (i_space_sign) begin
            sign_char = pdif_pkg::CHAR_SPACE;
        end else begin
            has_sign = 1'b0;
        end

        width_sat = (i_field_width > 7'(pdif_pkg::MAX_FIELD)) ?
                    7'(pdif_pkg::MAX_FIELD) : i_field_width;
    end

    // One shift-and-add-3 step per cycle
    always_comb begin
        for (int i = 0; i < pdif_pkg::NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        adj_flat   = adj;
        n_bcd_flat = {adj_flat[pdif_pkg::NUM_DIGITS*4-2:0], r_bin[pdif_pkg::VALUE_W-1]};
    end

    // Count significant digits and size the padding
    always_comb begin
        nd_raw = 5'd1;
        for (int i = 0; i < pdif_pkg::NUM_DIGITS; i++) begin
            nz[i] = (r_bcd[i] != 4'd0);
            if (nz[i]) begin
                nd_raw = 5'(i + 1);
            end
        end
        // zero at precision zero prints no digits
        nd    = (r_prec_given && (r_prec == 6'd0) && !(|nz)) ? 5'd0 : nd_raw;
        body  = (r_prec_given && ({1'b0, r_prec} > {2'b0, nd})) ?
                {1'b0, r_prec} : {2'b0, nd};
        total = body + {6'd0, r_has_sign};
        pad   = (r_width > total) ? (r_width - total) : 7'd0;
    end

    // Segment boundaries of the finished field
    always_comb begin
        lead  = (!r_left && !r_zp) ? r_pad : 7'd0;
        zeros = (r_zp ? r_pad : 7'd0) + (r_body - {2'b0, r_nd});
        trail = r_left ? r_pad : 7'd0;

        o_desc.bcd       = r_bcd;
        o_desc.sign_char = r_sign_char;
        o_desc.lead_end  = lead;
        o_desc.sign_end  = lead + {6'd0, r_has_sign};
        o_desc.zero_end  = o_desc.sign_end + zeros;
        o_desc.digit_end = o_desc.zero_end + {2'b0, r_nd};
        o_desc.total     = o_desc.digit_end + trail;
        field_empty      = (o_desc.total == 7'd0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdif_pkg::FS_IDLE:  if (i_valid) n_state = pdif_pkg::FS_CONV;
            pdif_pkg::FS_CONV:  if (r_iter == 7'd1) n_state = pdif_pkg::FS_COUNT;
            pdif_pkg::FS_COUNT: n_state = pdif_pkg::FS_PUSH;
            pdif_pkg::FS_PUSH: begin
                if (!i_q_status.full || field_empty) n_state = pdif_pkg::FS_IDLE;
            end
            default: n_state = pdif_pkg::FS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = (r_state == pdif_pkg::FS_IDLE);
        o_push  = (r_state == pdif_pkg::FS_PUSH) && !i_q_status.full && !field_empty;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdif_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin        <= load_bin;
            r_bcd        <= '0;
            r_iter       <= load_iter;
            r_sign_char  <= sign_char;
            r_has_sign   <= has_sign;
            r_left       <= i_left_align;
            r_zp         <= i_zero_pad && !i_left_align && !i_precision_given;
            r_prec_given <= i_precision_given;
            r_prec       <= i_digit_precision;
            r_width      <= width_sat;
        end else if (r_state == pdif_pkg::FS_CONV) begin
            r_bcd  <= n_bcd_flat;
            r_bin  <= {r_bin[pdif_pkg::VALUE_W-2:0], 1'b0};
            r_iter <= r_iter - 7'd1;
        end else if (r_state == pdif_pkg::FS_COUNT) begin
            r_nd   <= nd;
            r_body <= body;
            r_pad  <= pad;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdif_queue.sv =====
// Two-entry queue of field descriptors between front and back end.
// Depends on pdif_pkg.
`default_nettype none

module pdif_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pdif_pkg::t_desc  i_wr_data,
    input  wire logic             i_pop,
    output pdif_pkg::t_desc       o_rd_data,
    output pdif_pkg::t_q_status   o_status
);

    pdif_pkg::t_desc r_mem [pdif_pkg::QUEUE_DEPTH];
    logic [$clog2(pdif_pkg::QUEUE_DEPTH)-1:0] r_wr_ptr;
    logic [$clog2(pdif_pkg::QUEUE_DEPTH)-1:0] r_rd_ptr;
    logic [$clog2(pdif_pkg::QUEUE_DEPTH+1)-1:0] r_count;

    assign o_status.full  = (r_count == ($clog2(pdif_pkg::QUEUE_DEPTH+1))'(pdif_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdif_back.sv =====
// Back end: takes one field descriptor from the queue and emits its characters, one per
// cycle unless the output stalls, via a registered output stage. Depends on pdif_pkg.
`default_nettype none

module pdif_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pdif_pkg::t_q_status  i_q_status,
    input  wire pdif_pkg::t_desc      i_desc,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_out_char,
    output logic                      o_last_char
);

    pdif_pkg::t_desc                  r_desc;
    logic                             r_busy;
    logic [pdif_pkg::FIELD_W-1:0]     r_pos;
    logic                             r_valid;
    logic [7:0]                       r_char;
    logic                             r_last;

    logic                             emit;
    logic                             last;
    logic [7:0]                       n_char;
    logic [pdif_pkg::FIELD_W-1:0]     digit_off;

    assign o_pop       = !r_busy && !i_q_status.empty;
    assign emit        = r_busy && (!r_valid || i_ready);
    assign last        = (r_pos == (r_desc.total - 7'd1));
    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    // Pick the character at the current position
    always_comb begin
        digit_off = r_desc.digit_end - 7'd1 - r_pos;
        priority if (r_pos < r_desc.lead_end) begin
            n_char = pdif_pkg::CHAR_SPACE;
        end else if (r_pos < r_desc.sign_end) begin
            n_char = r_desc.sign_char;
        end else if (r_pos < r_desc.zero_end) begin
            n_char = pdif_pkg::CHAR_ZERO;
        end else if (r_pos < r_desc.digit_end) begin
            n_char = {pdif_pkg::DIGIT_HIGH_NIBBLE,
                      r_desc.bcd[digit_off[pdif_pkg::DIGIT_IDX_W-1:0]]};
        end else begin
            n_char = pdif_pkg::CHAR_SPACE;
        end
    end

    // Load a descriptor
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
    end

    // Walk the field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (emit) begin
            r_pos <= r_pos + 7'd1;
            if (last) r_busy <= 1'b0;
        end
    end

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= n_char;
            r_last <= last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/printf_decimal_integer_format_core.sv =====
// Top level of the decimal integer field formatter (%d / %u).
// Instantiates pdif_front, pdif_queue and pdif_back; depends on pdif_pkg.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_ready    i_func .. i_digit_precision
//   char      out        o_valid / i_ready    o_out_char, o_last_char
//
// The front end takes a request, runs the bit-serial BCD converter over 16, 32 or 64
// bits (short, int, long), then lays out the field and pushes it to the queue.
// The back end sends one character per cycle unless the output stalls, up to 64 per
// field, after loading each descriptor; a two-entry queue lets the two ends overlap.
// A field with no characters gives no output. Reset is synchronous, active low.
// An output stall holds the character register and backs up into the queue.
`default_nettype none

module printf_decimal_integer_format_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_func,
    input  wire logic signed [pdif_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [1:0]                           i_size_mode,
    input  wire logic                                 i_left_align,
    input  wire logic                                 i_force_plus,
    input  wire logic                                 i_space_sign,
    input  wire logic                                 i_zero_pad,
    input  wire logic [pdif_pkg::FIELD_W-1:0]         i_field_width,
    input  wire logic                                 i_precision_given,
    input  wire logic [pdif_pkg::PREC_W-1:0]          i_digit_precision,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [7:0]                                o_out_char,
    output logic                                      o_last_char
);

    logic                 push;
    logic                 pop;
    pdif_pkg::t_desc      wr_desc;
    pdif_pkg::t_desc      rd_desc;
    pdif_pkg::t_q_status  q_status;

    pdif_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_value           (i_value),
        .i_size_mode       (i_size_mode),
        .i_left_align      (i_left_align),
        .i_force_plus      (i_force_plus),
        .i_space_sign      (i_space_sign),
        .i_zero_pad        (i_zero_pad),
        .i_field_width     (i_field_width),
        .i_precision_given (i_precision_given),
        .i_digit_precision (i_digit_precision),
        .i_q_status        (q_status),
        .o_push            (push),
        .o_desc            (wr_desc)
    );

    pdif_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_desc),
        .i_pop     (pop),
        .o_rd_data (rd_desc),
        .o_status  (q_status)
    );

    pdif_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_desc      (rd_desc),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

`ifndef SYNTHESIS
    // The converter is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("front end ready right after accepting a request");

    // Never write a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("push into full queue");

    // Never read an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
